FILE: hdl/kvt_pkg.sv
// Shared types and constants for the key-value table with linear search.
`timescale 1ns / 1ps
package kvt_pkg;

  localparam int unsigned KEY_W  = 32;
  localparam int unsigned VAL_W  = 32;
  localparam int unsigned SLOT_W = 6;

  localparam logic CMD_SET  = 1'b0;
  localparam logic CMD_VIEW = 1'b1;

  typedef enum logic [2:0] {
    STAT_UPDATED   = 3'd0,
    STAT_INSERTED  = 3'd1,
    STAT_FOUND     = 3'd2,
    STAT_NOT_FOUND = 3'd3,
    STAT_FULL      = 3'd4,
    STAT_INVALID   = 3'd5
  } kvt_status_e;

  typedef enum logic [1:0] {
    KVT_IDLE,
    KVT_SEARCH,
    KVT_RESULT
  } kvt_state_e;

  // Write enables from the sequencer to the two memories.
  typedef struct packed {
    logic key_we;
    logic val_we;
  } kvt_wr_t;

  // Result handed from the sequencer to the output register.
  typedef struct packed {
    kvt_status_e       status;
    logic [VAL_W-1:0]  value;
    logic [SLOT_W-1:0] slot;
  } kvt_res_t;

endpackage

FILE: hdl/kvt_store.sv
// Key and value memories: one synchronous read port and one write port each.
`timescale 1ns / 1ps
module kvt_store #(
  parameter int unsigned CAPACITY = 64,
  parameter int unsigned AW       = 6
) (
  input  logic                   clk_i,
  input  logic                   rd_en_i,
  input  logic [AW-1:0]          rd_addr_i,
  input  kvt_pkg::kvt_wr_t       wr_i,
  input  logic [AW-1:0]          wr_addr_i,
  input  logic [kvt_pkg::KEY_W-1:0] wr_key_i,
  input  logic [kvt_pkg::VAL_W-1:0] wr_val_i,
  output logic [kvt_pkg::KEY_W-1:0] key_rdata_o,
  output logic [kvt_pkg::VAL_W-1:0] val_rdata_o
);
  import kvt_pkg::*;

  logic [KEY_W-1:0] key_mem [CAPACITY];
  logic [VAL_W-1:0] val_mem [CAPACITY];

  always_ff @(posedge clk_i) begin
    if (wr_i.key_we) begin
      key_mem[wr_addr_i] <= wr_key_i;
    end
    if (rd_en_i) begin
      key_rdata_o <= key_mem[rd_addr_i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i.val_we) begin
      val_mem[wr_addr_i] <= wr_val_i;
    end
    if (rd_en_i) begin
      val_rdata_o <= val_mem[rd_addr_i];
    end
  end

endmodule

FILE: hdl/kvt_search.sv
// Search sequencer: scans the stored keys one per cycle and decides each command.
`timescale 1ns / 1ps
module kvt_search #(
  parameter int unsigned CAPACITY = 64,
  parameter int unsigned AW       = 6,
  parameter int unsigned CW       = 7
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  // Command side.
  input  logic                      cmd_valid_i,
  output logic                      cmd_ready_o,
  input  logic                      cmd_i,
  input  logic [kvt_pkg::KEY_W-1:0] key_i,
  input  logic [kvt_pkg::VAL_W-1:0] val_i,
  // Memory side.
  output logic                      rd_en_o,
  output logic [AW-1:0]             rd_addr_o,
  output kvt_pkg::kvt_wr_t          wr_o,
  output logic [AW-1:0]             wr_addr_o,
  output logic [kvt_pkg::KEY_W-1:0] wr_key_o,
  output logic [kvt_pkg::VAL_W-1:0] wr_val_o,
  input  logic [kvt_pkg::KEY_W-1:0] key_rdata_i,
  input  logic [kvt_pkg::VAL_W-1:0] val_rdata_i,
  // Result side.
  output logic                      res_valid_o,
  input  logic                      res_ready_i,
  output kvt_pkg::kvt_res_t         res_o
);
  import kvt_pkg::*;

  kvt_state_e       state_q, state_d;
  logic [CW-1:0]    count_q, count_d;
  logic [CW-1:0]    issue_q, issue_d;
  logic             pend_q, pend_d;
  logic [AW-1:0]    pend_idx_q, pend_idx_d;
  logic             cmd_q, cmd_d;
  logic [KEY_W-1:0] key_q, key_d;
  logic [VAL_W-1:0] val_q, val_d;
  kvt_res_t         res_q, res_d;

  logic accept;
  logic key_ok;
  logic hit;
  logic miss;
  logic full;

  assign cmd_ready_o = (state_q == KVT_IDLE);
  assign res_valid_o = (state_q == KVT_RESULT);

  assign accept = cmd_valid_i && cmd_ready_o;
  assign key_ok = (key_i != '0) && !key_i[KEY_W-1];
  assign hit    = (state_q == KVT_SEARCH) && pend_q && (key_rdata_i == key_q);
  assign miss   = (state_q == KVT_SEARCH) && !pend_q && (issue_q == count_q);
  assign full   = (count_q == CW'(CAPACITY));

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      KVT_IDLE: begin
        if (accept) begin
          state_d = key_ok ? KVT_SEARCH : KVT_RESULT;
        end
      end
      KVT_SEARCH: begin
        if (hit || miss) begin
          state_d = KVT_RESULT;
        end
      end
      KVT_RESULT: begin
        if (res_ready_i) begin
          state_d = KVT_IDLE;
        end
      end
      default: state_d = KVT_IDLE;
    endcase
  end

  // Datapath and memory control.
  always_comb begin
    count_d    = count_q;
    issue_d    = issue_q;
    pend_d     = 1'b0;
    pend_idx_d = pend_idx_q;
    cmd_d      = cmd_q;
    key_d      = key_q;
    val_d      = val_q;
    res_d      = res_q;
    rd_en_o    = 1'b0;
    wr_o       = '0;
    wr_addr_o  = count_q[AW-1:0];

    case (state_q)
      KVT_IDLE: begin
        issue_d = '0;
        if (accept) begin
          cmd_d = cmd_i;
          key_d = key_i;
          val_d = val_i;
          res_d = '{status: STAT_INVALID, value: '0, slot: '0};
        end
      end
      KVT_SEARCH: begin
        if (hit) begin
          wr_addr_o = pend_idx_q;
          if (cmd_q == CMD_VIEW) begin
            res_d = '{status: STAT_FOUND, value: val_rdata_i, slot: SLOT_W'(pend_idx_q)};
          end else begin
            wr_o.val_we = 1'b1;
            res_d = '{status: STAT_UPDATED, value: val_q, slot: SLOT_W'(pend_idx_q)};
          end
        end else if (miss) begin
          if (cmd_q == CMD_VIEW) begin
            res_d = '{status: STAT_NOT_FOUND, value: '0, slot: '0};
          end else if (full) begin
            res_d = '{status: STAT_FULL, value: '0, slot: '0};
          end else begin
            wr_o    = '{key_we: 1'b1, val_we: 1'b1};
            count_d = count_q + CW'(1);
            res_d   = '{status: STAT_INSERTED, value: val_q, slot: SLOT_W'(count_q[AW-1:0])};
          end
        end else if (issue_q < count_q) begin
          // Keep one read in flight: issue the next slot while comparing this one.
          rd_en_o    = 1'b1;
          pend_d     = 1'b1;
          pend_idx_d = issue_q[AW-1:0];
          issue_d    = issue_q + CW'(1);
        end
      end
      KVT_RESULT: begin
      end
      default: begin
      end
    endcase
  end

  assign rd_addr_o = issue_q[AW-1:0];
  assign wr_key_o  = key_q;
  assign wr_val_o  = val_q;
  assign res_o     = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= KVT_IDLE;
      count_q <= '0;
      issue_q <= '0;
      pend_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      issue_q <= issue_d;
      pend_q  <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_idx_q <= pend_idx_d;
    cmd_q      <= cmd_d;
    key_q      <= key_d;
    val_q      <= val_d;
    res_q      <= res_d;
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(CAPACITY))
    else $error("entry count beyond capacity");

  a_insert_counts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_o.key_we |=> count_q == $past(count_q) + CW'(1))
    else $error("key written without a new entry");

  a_read_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q |-> ({1'b0, pend_idx_q} < {1'b0, count_q}))
    else $error("compared a slot that holds no entry");

  a_no_read_on_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wr_o.key_we || wr_o.val_we) |-> !rd_en_o && (state_q == KVT_SEARCH))
    else $error("memory write outside the decision cycle");

endmodule

FILE: hdl/key_value_table_linear_search.sv
// Top level of the key-value table with linear search.
`timescale 1ns / 1ps
// Key-value table searched linearly from slot 0.
// Slave channel: one word per command. tuser carries the command (0 set, 1 view);
// tdata carries the key in bits 31:0 and the value in bits 63:32, both signed.
// Master channel: one word per command. tuser carries the status (0 updated,
// 1 inserted, 2 found, 3 not found, 4 table full, 5 invalid key); tdata carries
// the value in bits 31:0 and the slot in bits 37:32, upper bits zero.
// A key below 1 is answered as invalid and leaves the table untouched; a set of
// a new key into a full table is answered as full and stores nothing.
// A command whose key is found in slot s answers once slots 0 to s have been read;
// a miss answers once every stored entry has been compared, and a command on an
// empty table answers without reading the memories. The sequencer is ready for the
// next command in the cycle after it hands over a result. The scan is paced by the
// key memory, which delivers one stored key per cycle. An invalid key goes straight
// to the result without a search. One command at a time.
// The result sits in an output register; a new command is taken while it waits,
// and if the receiver stalls the sequencer holds the next result until the
// register frees up. Reset empties the table at once (the entry count clears),
// with no clearing pass; the memories themselves are not cleared.
module key_value_table_linear_search #(
  parameter int unsigned CAPACITY = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,   // key [31:0], value [63:32]
  input  logic [0:0]  s_axis_tuser,   // command [0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // value_out [31:0], slot [37:32], zero [39:38]
  output logic [2:0]  m_axis_tuser    // status [2:0]
);
  import kvt_pkg::*;

  // Address width of the memories, and width of a count that can reach CAPACITY.
  localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CW = $clog2(CAPACITY + 1);

  logic             rd_en;
  logic [AW-1:0]    rd_addr;
  kvt_wr_t          wr;
  logic [AW-1:0]    wr_addr;
  logic [KEY_W-1:0] wr_key;
  logic [VAL_W-1:0] wr_val;
  logic [KEY_W-1:0] key_rdata;
  logic [VAL_W-1:0] val_rdata;

  logic     res_valid;
  logic     res_ready;
  kvt_res_t res;

  // Output register, the only buffer between the sequencer and the receiver.
  logic     out_valid_q, out_valid_d;
  kvt_res_t out_q, out_d;

  kvt_store #(
    .CAPACITY (CAPACITY),
    .AW       (AW)
  ) u_store (
    .clk_i       (clk_i),
    .rd_en_i     (rd_en),
    .rd_addr_i   (rd_addr),
    .wr_i        (wr),
    .wr_addr_i   (wr_addr),
    .wr_key_i    (wr_key),
    .wr_val_i    (wr_val),
    .key_rdata_o (key_rdata),
    .val_rdata_o (val_rdata)
  );

  kvt_search #(
    .CAPACITY (CAPACITY),
    .AW       (AW),
    .CW       (CW)
  ) u_search (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (s_axis_tvalid),
    .cmd_ready_o (s_axis_tready),
    .cmd_i       (s_axis_tuser[0]),
    .key_i       (s_axis_tdata[31:0]),
    .val_i       (s_axis_tdata[63:32]),
    .rd_en_o     (rd_en),
    .rd_addr_o   (rd_addr),
    .wr_o        (wr),
    .wr_addr_o   (wr_addr),
    .wr_key_o    (wr_key),
    .wr_val_o    (wr_val),
    .key_rdata_i (key_rdata),
    .val_rdata_i (val_rdata),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res)
  );

  // The register accepts a new result when empty or when its word leaves now.
  assign res_ready = !out_valid_q || m_axis_tready;

  always_comb begin
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (res_valid && res_ready) begin
      out_valid_d = 1'b1;
      out_d       = res;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_q.status;
  assign m_axis_tdata  = {2'b00, out_q.slot, out_q.value};

  a_no_result_lost: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !m_axis_tready) |=> out_valid_q && $stable(out_q))
    else $error("stalled result word overwritten");

  a_result_consumed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid && res_ready) |=> out_valid_q && (out_q == $past(res)))
    else $error("sequencer result not captured");

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("second command taken while one is in progress");

endmodule
